// ===== rtl/bsse_pkg.sv =====
// Package for the B-spline surface evaluator: payload structs, codes,
// sizes and sequencer states. No dependencies.
package bsse_pkg;

   localparam int DEF_MAX_DEGREE  = 3;
   localparam int DEF_MAX_COLUMNS = 16;
   localparam int DEF_MAX_ROWS    = 16;

   localparam int ONE_Q16   = 65536;
   localparam int HALF_Q16  = 32768;
   localparam int DIV_BITS  = 49;   // |(t - knot)| << 16 fits in 49 bits
   localparam int DEN_BITS  = 33;   // |knot difference| fits in 33 bits
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   localparam logic [1:0] REQ_LOAD_U = 2'd0;
   localparam logic [1:0] REQ_LOAD_V = 2'd1;
   localparam logic [1:0] REQ_LOAD_P = 2'd2;
   localparam logic [1:0] REQ_EVAL   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_DEG_U  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEG_V  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESH = 3'd4;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [4:0]         knot_or_column_index;
      logic [3:0]         row_index;
      logic signed [31:0] knot_value;
      logic signed [31:0] coord_x;
      logic signed [31:0] coord_y;
      logic signed [31:0] coord_z;
      logic signed [31:0] param_u;
      logic signed [31:0] param_v;
   } bsse_req_type;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
   } bsse_rsp_type;

   // Element 0 is x, 1 is y, 2 is z.
   typedef logic [2:0][31:0] pt_type;

   typedef enum logic [4:0] {
      S_IDLE, S_LO, S_HI, S_HIW, S_SPAN, S_SPANW, S_LD, S_LDW,
      S_DA, S_DB, S_DC, S_DIV, S_W0, S_W1, S_W2, S_INT, S_INTW,
      S_WB, S_RES, S_RESW, S_OUT
   } state_type;

endpackage

// ===== rtl/bsse_div.sv =====
// Iterative restoring divider that produces the de Boor alpha in Q1.16.
// Depends on bsse_pkg.
module bsse_div import bsse_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [32:0] num,
   input  logic signed [32:0] den,
   output logic               done,
   output logic [16:0]        alpha
);

   logic [DIV_BITS-1:0] quo_ff, quo_in;
   logic [DEN_BITS:0]   rem_ff, rem_in;
   logic [DEN_BITS-1:0] den_ff, den_in;
   logic                neg_ff, neg_in;
   logic [5:0]          cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DEN_BITS:0]   rem_sh;
   logic [32:0]         num_mag;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      num_mag = num[32] ? 33'(-num) : 33'(num);
      rem_sh  = {rem_ff[DEN_BITS-1:0], quo_ff[DIV_BITS-1]};
      if (start) begin
         quo_in  = {num_mag, 16'd0};
         rem_in  = '0;
         den_in  = den[32] ? 33'(-den) : 33'(den);
         neg_in  = num[32] ^ den[32];
         cnt_in  = 6'(DIV_BITS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sh - {1'b0, den_ff};
            quo_in = {quo_ff[DIV_BITS-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[DIV_BITS-2:0], 1'b0};
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // A negative quotient clamps to zero, a large one to one.
   always_comb begin
      if (neg_ff) begin
         alpha = '0;
      end else if (quo_ff > DIV_BITS'(ONE_Q16)) begin
         alpha = 17'(ONE_Q16);
      end else begin
         alpha = quo_ff[16:0];
      end
   end

   assign done = done_ff;

endmodule

// ===== rtl/bsse_interp.sv =====
// Two-stage interpolation unit: d0 + round((d1 - d0) * alpha / 2^16).
// Depends on bsse_pkg.
module bsse_interp import bsse_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] d0,
   input  logic signed [31:0] d1,
   input  logic [16:0]        alpha,
   output logic               done,
   output logic [31:0]        result
);

   logic signed [50:0] prod_ff, prod_in;
   logic signed [31:0] base_ff;
   logic signed [32:0] diff;
   logic signed [34:0] sum;
   logic               v1_ff, v2_ff;
   logic [31:0]        res_ff, res_in;

   always_comb begin
      diff    = 33'(d1) - 33'(d0);
      prod_in = 51'(diff * $signed({1'b0, alpha})) + 51'(HALF_Q16);
      sum     = 35'(base_ff) + 35'(prod_ff >>> 16);
      res_in  = sum[31:0];
   end

   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff <= prod_in;
         base_ff <= d0;
      end
      res_ff <= res_in;
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
      end
   end

   assign done   = v2_ff;
   assign result = res_ff;

endmodule

// ===== rtl/bspline_surface_evaluator.sv =====
// Top level of the B-spline surface evaluator: stores, sequencer, output.
// Depends on bsse_pkg, bsse_div and bsse_interp.
//
// Usage: the req_ channel carries one transaction per request. A load
// transaction writes one u knot, one v knot or one control point into the
// stores in the cycle it is accepted and returns nothing. An evaluate
// transaction clamps u and v to their domains, runs de Boor in u on every
// control point row into a column buffer, then de Boor in v on that column,
// and returns one point on the rsp_ channel.
// An evaluate runs one de Boor pass per row plus one. Each pass clamps the
// parameter, searches the knots for the span, loads p+1 points into the work
// store, runs p(p+1)/2 steps and reads out the result. A step reads two knots,
// divides in the 49-step serial divider, runs three interpolations that share
// one multiplier and reads and writes the work store. A step whose knot
// difference is at or below the threshold skips the divider. req_ready is low
// while an evaluate runs.
// The csr_ port writes configuration registers; write only while idle.
// Reset clears control state and loads the register reset values; the knot
// and point stores hold nothing defined until written. When the receiver
// stalls, the result waits in the output register, and the block keeps
// taking load transactions; a second result waits until the first is taken.
module bspline_surface_evaluator import bsse_pkg::*; #(
   parameter int MAX_DEGREE  = DEF_MAX_DEGREE,
   parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  bsse_req_type         req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output bsse_rsp_type         rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   localparam int KNOT_DEPTH = ((MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS)
                               + MAX_DEGREE + 1;
   localparam int KW         = $clog2(KNOT_DEPTH);
   localparam int RW         = $clog2(MAX_ROWS);
   localparam int GRID_DEPTH = MAX_ROWS * MAX_COLUMNS;
   localparam int GW         = $clog2(GRID_DEPTH);
   localparam int WORK_DEPTH = MAX_DEGREE + 1;
   localparam int WW         = (WORK_DEPTH > 2) ? $clog2(WORK_DEPTH) : 1;

   // Configuration registers.
   logic [1:0]  deg_u_ff, deg_v_ff;
   logic [4:0]  cols_ff, rows_ff;
   logic [15:0] thresh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         deg_u_ff  <= 2'd3;
         deg_v_ff  <= 2'd3;
         cols_ff   <= 5'd16;
         rows_ff   <= 5'd16;
         thresh_ff <= 16'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DEG_U:  deg_u_ff  <= csr_wdata[1:0];
            CSR_DEG_V:  deg_v_ff  <= csr_wdata[1:0];
            CSR_COLS:   cols_ff   <= csr_wdata[4:0];
            CSR_ROWS:   rows_ff   <= csr_wdata[4:0];
            CSR_THRESH: thresh_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stores. Each one is written at one address and read at one address
   // with registered read data.
   logic [31:0] u_mem [KNOT_DEPTH];
   logic [31:0] v_mem [KNOT_DEPTH];
   pt_type      grid_mem [GRID_DEPTH];
   pt_type      col_mem [MAX_ROWS];
   pt_type      work_mem [WORK_DEPTH];

   logic          ku_we, kv_we, grid_we, col_we, work_we;
   logic [KW-1:0] kw_addr, knot_ra;
   logic [GW-1:0] grid_wa, grid_ra;
   logic [RW-1:0] col_wa, col_ra;
   logic [WW-1:0] work_wa, work_ra;
   pt_type        grid_wd, col_wd, work_wd;
   logic [31:0]   ku_q_ff, kv_q_ff;
   pt_type        grid_q_ff, col_q_ff, work_q_ff;

   always_ff @(posedge clock) begin
      if (ku_we)   u_mem[kw_addr]    <= req_data.knot_value;
      if (kv_we)   v_mem[kw_addr]    <= req_data.knot_value;
      if (grid_we) grid_mem[grid_wa] <= grid_wd;
      if (col_we)  col_mem[col_wa]   <= col_wd;
      if (work_we) work_mem[work_wa] <= work_wd;
      ku_q_ff   <= u_mem[knot_ra];
      kv_q_ff   <= v_mem[knot_ra];
      grid_q_ff <= grid_mem[grid_ra];
      col_q_ff  <= col_mem[col_ra];
      work_q_ff <= work_mem[work_ra];
   end

   // Sequencer registers.
   state_type          state_ff, state_in;
   logic               pass_ff, pass_in;        // 0: rows in u, 1: column in v
   logic [RW-1:0]      row_ff, row_in;
   logic [KW-1:0]      p_ff, p_in, q_ff, q_in;
   logic [KW-1:0]      ncol_ff, ncol_in, nrow_ff, nrow_in;
   logic [KW-1:0]      deg_ff, deg_in, last_ff, last_in;
   logic [KW-1:0]      k_ff, k_in, j_ff, j_in, r_ff, r_in;
   logic signed [31:0] t_ff, t_in, pu_ff, pu_in, pv_ff, pv_in;
   logic signed [31:0] kh_ff, kh_in;
   logic [16:0]        alpha_ff, alpha_in;
   pt_type             d0_ff, d0_in, d1_ff, d1_in, new_ff, new_in;
   logic [1:0]         c_ff, c_in;
   logic               rsp_valid_ff, rsp_valid_in;
   bsse_rsp_type       rsp_data_ff, rsp_data_in;

   // Shared units.
   logic               div_start, div_done, int_start, int_done;
   logic [16:0]        div_alpha;
   logic [31:0]        int_res;
   logic signed [32:0] den, num;

   bsse_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num),
      .den   (den),
      .done  (div_done),
      .alpha (div_alpha)
   );

   bsse_interp u_interp (
      .clock  (clock),
      .reset  (reset),
      .start  (int_start),
      .d0     ($signed(d0_ff[c_ff])),
      .d1     ($signed(d1_ff[c_ff])),
      .alpha  (alpha_ff),
      .done   (int_done),
      .result (int_res)
   );

   logic signed [31:0] knot_q;
   logic [KW-1:0]      pt_idx, span_idx;
   logic signed [32:0] den_mag;
   logic               accept;
   int                 pe, qe, nc, nr;

   assign knot_q   = pass_ff ? $signed(kv_q_ff) : $signed(ku_q_ff);
   assign pt_idx   = k_ff - deg_ff + j_ff;
   assign span_idx = pt_idx;
   assign accept   = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      pass_in      = pass_ff;
      row_in       = row_ff;
      p_in         = p_ff;
      q_in         = q_ff;
      ncol_in      = ncol_ff;
      nrow_in      = nrow_ff;
      deg_in       = deg_ff;
      last_in      = last_ff;
      k_in         = k_ff;
      j_in         = j_ff;
      r_in         = r_ff;
      t_in         = t_ff;
      pu_in        = pu_ff;
      pv_in        = pv_ff;
      kh_in        = kh_ff;
      alpha_in     = alpha_ff;
      d0_in        = d0_ff;
      d1_in        = d1_ff;
      new_in       = new_ff;
      c_in         = c_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      req_ready    = 1'b0;
      ku_we        = 1'b0;
      kv_we        = 1'b0;
      grid_we      = 1'b0;
      col_we       = 1'b0;
      work_we      = 1'b0;
      kw_addr      = KW'(req_data.knot_or_column_index);
      knot_ra      = '0;
      grid_wa      = GW'(int'(req_data.row_index) * MAX_COLUMNS
                         + int'(req_data.knot_or_column_index));
      grid_wd      = {req_data.coord_z, req_data.coord_y, req_data.coord_x};
      grid_ra      = GW'(int'(row_ff) * MAX_COLUMNS + int'(pt_idx));
      col_wa       = row_ff;
      col_ra       = RW'(pt_idx);
      col_wd       = work_q_ff;
      work_wa      = WW'(j_ff);
      work_wd      = pass_ff ? col_q_ff : grid_q_ff;
      work_ra      = WW'(j_ff);
      div_start    = 1'b0;
      int_start    = 1'b0;
      den          = 33'(kh_ff) - 33'(knot_q);
      num          = 33'(t_ff) - 33'(knot_q);
      den_mag      = den[32] ? -den : den;

      // Effective degrees and counts for an evaluate.
      nc = (cols_ff < 5'd2) ? 2 : ((int'(cols_ff) > MAX_COLUMNS) ? MAX_COLUMNS
                                                                 : int'(cols_ff));
      nr = (rows_ff < 5'd2) ? 2 : ((int'(rows_ff) > MAX_ROWS) ? MAX_ROWS
                                                              : int'(rows_ff));
      pe = (deg_u_ff == 2'd0) ? 1 : ((int'(deg_u_ff) > MAX_DEGREE) ? MAX_DEGREE
                                                                  : int'(deg_u_ff));
      qe = (deg_v_ff == 2'd0) ? 1 : ((int'(deg_v_ff) > MAX_DEGREE) ? MAX_DEGREE
                                                                  : int'(deg_v_ff));
      if (pe > nc - 1) pe = nc - 1;
      if (qe > nr - 1) qe = nr - 1;

      // The output register empties when the receiver takes the result.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               unique case (req_data.req_type)
                  REQ_LOAD_U: begin
                     ku_we = int'(req_data.knot_or_column_index) < KNOT_DEPTH;
                  end
                  REQ_LOAD_V: begin
                     kv_we = int'(req_data.knot_or_column_index) < KNOT_DEPTH;
                  end
                  REQ_LOAD_P: begin
                     grid_we = (int'(req_data.knot_or_column_index) < MAX_COLUMNS)
                               && (int'(req_data.row_index) < MAX_ROWS);
                  end
                  REQ_EVAL: begin
                     p_in     = KW'(pe);
                     q_in     = KW'(qe);
                     ncol_in  = KW'(nc);
                     nrow_in  = KW'(nr);
                     pu_in    = req_data.param_u;
                     pv_in    = req_data.param_v;
                     pass_in  = 1'b0;
                     row_in   = '0;
                     deg_in   = KW'(pe);
                     last_in  = KW'(nc - 1);
                     t_in     = req_data.param_u;
                     state_in = S_LO;
                  end
                  default: ;
               endcase
            end
         end
         S_LO: begin
            knot_ra  = deg_ff;
            state_in = S_HI;
         end
         S_HI: begin
            knot_ra  = last_ff + KW'(1);
            if (t_ff < knot_q) t_in = knot_q;
            state_in = S_HIW;
         end
         S_HIW: begin
            // The upper domain bound wins over the lower one.
            if (t_ff > knot_q) t_in = knot_q;
            k_in     = deg_ff;
            j_in     = deg_ff;
            state_in = S_SPAN;
         end
         S_SPAN: begin
            knot_ra  = j_ff;
            state_in = S_SPANW;
         end
         S_SPANW: begin
            if (knot_q <= t_ff) k_in = j_ff;
            if (j_ff == last_ff) begin
               j_in     = '0;
               state_in = S_LD;
            end else begin
               j_in     = j_ff + KW'(1);
               state_in = S_SPAN;
            end
         end
         S_LD: begin
            state_in = S_LDW;
         end
         S_LDW: begin
            work_we = 1'b1;
            if (j_ff == deg_ff) begin
               r_in     = KW'(1);
               state_in = S_DA;
            end else begin
               j_in     = j_ff + KW'(1);
               state_in = S_LD;
            end
         end
         S_DA: begin
            knot_ra  = span_idx + deg_ff + KW'(1) - r_ff;
            state_in = S_DB;
         end
         S_DB: begin
            kh_in    = knot_q;
            knot_ra  = span_idx;
            state_in = S_DC;
         end
         S_DC: begin
            // A knot difference at or below the threshold forces alpha to zero.
            if (den_mag > 33'(thresh_ff)) begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end else begin
               alpha_in = '0;
               state_in = S_W0;
            end
         end
         S_DIV: begin
            if (div_done) begin
               alpha_in = div_alpha;
               state_in = S_W0;
            end
         end
         S_W0: begin
            work_ra  = WW'(j_ff - KW'(1));
            state_in = S_W1;
         end
         S_W1: begin
            d0_in    = work_q_ff;
            state_in = S_W2;
         end
         S_W2: begin
            d1_in    = work_q_ff;
            c_in     = '0;
            state_in = S_INT;
         end
         S_INT: begin
            int_start = 1'b1;
            state_in  = S_INTW;
         end
         S_INTW: begin
            if (int_done) begin
               new_in[c_ff] = int_res;
               if (c_ff == 2'd2) begin
                  state_in = S_WB;
               end else begin
                  c_in     = c_ff + 2'd1;
                  state_in = S_INT;
               end
            end
         end
         S_WB: begin
            work_we = 1'b1;
            work_wd = new_ff;
            if (j_ff == r_ff) begin
               if (r_ff == deg_ff) begin
                  state_in = S_RES;
               end else begin
                  r_in     = r_ff + KW'(1);
                  j_in     = deg_ff;
                  state_in = S_DA;
               end
            end else begin
               j_in     = j_ff - KW'(1);
               state_in = S_DA;
            end
         end
         S_RES: begin
            work_ra  = WW'(deg_ff);
            state_in = S_RESW;
         end
         S_RESW: begin
            if (!pass_ff) begin
               col_we = 1'b1;
               if (KW'(row_ff) == nrow_ff - KW'(1)) begin
                  pass_in = 1'b1;
                  deg_in  = q_ff;
                  last_in = nrow_ff - KW'(1);
                  t_in    = pv_ff;
               end else begin
                  row_in  = row_ff + RW'(1);
                  deg_in  = p_ff;
                  last_in = ncol_ff - KW'(1);
                  t_in    = pu_ff;
               end
               state_in = S_LO;
            end else begin
               new_in   = work_q_ff;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in        = 1'b1;
               rsp_data_in.point_x = $signed(new_ff[0]);
               rsp_data_in.point_y = $signed(new_ff[1]);
               rsp_data_in.point_z = $signed(new_ff[2]);
               state_in            = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      pass_ff     <= pass_in;
      row_ff      <= row_in;
      p_ff        <= p_in;
      q_ff        <= q_in;
      ncol_ff     <= ncol_in;
      nrow_ff     <= nrow_in;
      deg_ff      <= deg_in;
      last_ff     <= last_in;
      k_ff        <= k_in;
      j_ff        <= j_in;
      r_ff        <= r_in;
      t_ff        <= t_in;
      pu_ff       <= pu_in;
      pv_ff       <= pv_in;
      kh_ff       <= kh_in;
      alpha_ff    <= alpha_in;
      d0_ff       <= d0_in;
      d1_ff       <= d1_in;
      new_ff      <= new_in;
      c_ff        <= c_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/bsse_checker.sv =====
// Port-level checker for the B-spline surface evaluator and its bind.
// Depends on bsse_pkg and bspline_surface_evaluator.
module bsse_checker import bsse_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input bsse_req_type req_data,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input bsse_rsp_type rsp_data
);

   logic eval_acc;
   logic load_acc;

   assign eval_acc = req_valid && req_ready && (req_data.req_type == REQ_EVAL);
   assign load_acc = req_valid && req_ready && (req_data.req_type != REQ_EVAL);

   // A stalled result keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // Reset empties the output register.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // An evaluate keeps the block busy after it is accepted.
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      eval_acc |=> !req_ready ##1 !req_ready)
      else $error("ready too soon after evaluate");

   // A load finishes at once and the block stays ready.
   a_load_ready: assert property (@(posedge clock) disable iff (reset)
      load_acc |=> req_ready)
      else $error("not ready after load");

endmodule

bind bspline_surface_evaluator bsse_checker u_bsse_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== tb/sv/tb_bspline_surface_evaluator.sv =====
// Self-checking testbench for bspline_surface_evaluator: a surface predictor
// in SystemVerilog checks every evaluated point. Depends on bsse_pkg and the RTL.
module tb_bspline_surface_evaluator;
   import bsse_pkg::*;

   localparam int KNOTS        = 20;
   localparam int LOADED_KNOTS = 8;   // enough for four points at degree three
   localparam int GRID_SIDE    = 4;
   localparam int CYCLE_CAP    = 3000000;
   localparam int EVAL_SLACK   = 5000;

   typedef logic signed [63:0] wide_type;
   typedef wide_type point_type [3];

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   bsse_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   bsse_rsp_type rsp_data;
   logic         csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   bspline_surface_evaluator i_dut (.*);

   always #5 clock = ~clock;

   // Predictor state: a copy of the surface stores and the registers.
   wide_type    u_knots [KNOTS];
   wide_type    v_knots [KNOTS];
   point_type   grid [16][16];
   int unsigned deg_u_reg, deg_v_reg, cols_reg, rows_reg, thresh_reg;

   bsse_req_type pending_requests [$];
   bsse_rsp_type expected_points [$];

   int send_idle_pct, recv_idle_pct;
   int hold_off_cycles;
   int mismatches, cycle_count;

   // Q16.16 floor division by one, used by the rounded interpolation.
   function automatic wide_type floor_one(wide_type x);
      if (x >= 0) return x / ONE_Q16;
      return -((-x + ONE_Q16 - 1) / ONE_Q16);
   endfunction

   // One de Boor pass over n+1 points with degree p at parameter t.
   function automatic point_type curve_point(point_type pts [16], wide_type kn [KNOTS],
                                             int p, int n, wide_type t);
      point_type work [4];
      int k;
      wide_type den, mag, alpha;
      k = p;
      if (t < kn[p]) t = kn[p];
      if (t > kn[n+1]) t = kn[n+1];
      for (int j = p; j <= n; j++) if (kn[j] <= t) k = j;
      for (int j = 0; j <= p; j++) work[j] = pts[k-p+j];
      for (int r = 1; r <= p; r++) begin
         for (int j = p; j >= r; j--) begin
            den = kn[k-p+j+p+1-r] - kn[k-p+j];
            mag = den < 0 ? -den : den;
            alpha = 0;
            if (mag > thresh_reg) begin
               alpha = ((t - kn[k-p+j]) * ONE_Q16) / den;
               if (alpha < 0) alpha = 0;
               if (alpha > ONE_Q16) alpha = ONE_Q16;
            end
            for (int c = 0; c < 3; c++)
               work[j][c] = work[j-1][c]
                  + floor_one((work[j][c] - work[j-1][c]) * alpha + HALF_Q16);
         end
      end
      return work[p];
   endfunction

   // Applies one request to the predictor and queues the point it yields.
   function automatic void predict_surface(bsse_req_type rq);
      point_type column [16];
      point_type res;
      int ncol, nrow, p, q;
      bsse_rsp_type pt;
      case (rq.req_type)
         REQ_LOAD_U: if (rq.knot_or_column_index < KNOTS)
            u_knots[rq.knot_or_column_index] = rq.knot_value;
         REQ_LOAD_V: if (rq.knot_or_column_index < KNOTS)
            v_knots[rq.knot_or_column_index] = rq.knot_value;
         REQ_LOAD_P: if (rq.knot_or_column_index < 16) begin
            grid[rq.row_index][rq.knot_or_column_index][0] = rq.coord_x;
            grid[rq.row_index][rq.knot_or_column_index][1] = rq.coord_y;
            grid[rq.row_index][rq.knot_or_column_index][2] = rq.coord_z;
         end
         default: begin
            ncol = cols_reg < 2 ? 2 : (cols_reg > 16 ? 16 : cols_reg);
            nrow = rows_reg < 2 ? 2 : (rows_reg > 16 ? 16 : rows_reg);
            p = deg_u_reg < 1 ? 1 : deg_u_reg;
            q = deg_v_reg < 1 ? 1 : deg_v_reg;
            if (p > ncol - 1) p = ncol - 1;
            if (q > nrow - 1) q = nrow - 1;
            for (int j = 0; j < 16; j++) column[j] = '{0, 0, 0};
            for (int j = 0; j < nrow; j++)
               column[j] = curve_point(grid[j], u_knots, p, ncol - 1, rq.param_u);
            res = curve_point(column, v_knots, q, nrow - 1, rq.param_v);
            pt.point_x = res[0][31:0];
            pt.point_y = res[1][31:0];
            pt.point_z = res[2][31:0];
            expected_points.push_back(pt);
         end
      endcase
   endfunction

   // Driver: offers queued transactions, idling at random between them.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_surface(req_data);
         end
         if (!req_valid || req_ready) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data  <= pending_requests.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each returned point and drives receiver back-pressure.
   // A long hold-off, counted here, lets the sender run into a busy block.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_points.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected point %h", rsp_data);
            end else begin
               automatic bsse_rsp_type exp_pt = expected_points.pop_front();
               if (exp_pt.point_x !== rsp_data.point_x || exp_pt.point_y !== rsp_data.point_y
                   || exp_pt.point_z !== rsp_data.point_z) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("point mismatch: expected %h %h %h, got %h %h %h",
                              exp_pt.point_x, exp_pt.point_y, exp_pt.point_z,
                              rsp_data.point_x, rsp_data.point_y, rsp_data.point_z);
               end
            end
         end
         if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Cycle cap guards against a hung block.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic bsse_req_type make_req(logic [1:0] kind, int idx, int row,
                                             logic [31:0] kv, logic [31:0] x,
                                             logic [31:0] y, logic [31:0] z,
                                             logic [31:0] u, logic [31:0] v);
      bsse_req_type rq;
      rq.req_type = kind;
      rq.knot_or_column_index = 5'(idx);
      rq.row_index = 4'(row);
      rq.knot_value = kv;
      rq.coord_x = x;
      rq.coord_y = y;
      rq.coord_z = z;
      rq.param_u = u;
      rq.param_v = v;
      return rq;
   endfunction

   function automatic logic [31:0] rnd32();
      return $urandom;
   endfunction

   // Loads a non-decreasing knot vector, its first four knots equal, and a
   // four by four grid so that every later evaluation, with at most four
   // columns and rows, reads only written entries. Coordinates may be huge;
   // the interpolation stays within its two end points.
   task automatic load_surface(bit wild);
      int kv;
      for (int axis = 0; axis < 2; axis++) begin
         kv = wild ? -($urandom_range(1 << 20)) : 0;
         for (int i = 0; i < LOADED_KNOTS; i++) begin
            if (i > 3 && $urandom_range(3) != 0) kv += $urandom_range(wild ? 1 << 19 : 1 << 17);
            pending_requests.push_back(make_req(axis ? REQ_LOAD_V : REQ_LOAD_U, i,
                                                $urandom_range(15), kv, rnd32(), rnd32(),
                                                rnd32(), rnd32(), rnd32()));
         end
      end
      for (int r = 0; r < GRID_SIDE; r++)
         for (int c = 0; c < GRID_SIDE; c++)
            pending_requests.push_back(make_req(REQ_LOAD_P, c, r, rnd32(),
               wild ? rnd32() : $urandom_range(1 << 22),
               wild ? rnd32() : $urandom_range(1 << 22), rnd32(), rnd32(), rnd32()));
   endtask

   task automatic drain();
      while (pending_requests.size() > 0 || req_valid || expected_points.size() > 0)
         @(posedge clock);
      repeat (EVAL_SLACK) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, int value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DAT_W'(value);
      case (idx)
         CSR_DEG_U:  deg_u_reg  = value & 3;
         CSR_DEG_V:  deg_v_reg  = value & 3;
         CSR_COLS:   cols_reg   = value & 31;
         CSR_ROWS:   rows_reg   = value & 31;
         default:    thresh_reg = value & 16'hFFFF;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic add_evals(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(9) == 0)
            pending_requests.push_back(make_req(2'($urandom_range(2)), $urandom_range(20, 31),
               $urandom_range(15), rnd32(), rnd32(), rnd32(), rnd32(), rnd32(), rnd32()));
         pending_requests.push_back(make_req(REQ_EVAL, $urandom_range(31), $urandom_range(15),
            rnd32(), rnd32(), rnd32(), rnd32(),
            $urandom_range(3) == 0 ? rnd32() : $urandom_range(1 << 21),
            $urandom_range(3) == 0 ? rnd32() : $urandom_range(1 << 21)));
      end
   endtask

   initial begin
      deg_u_reg = 3; deg_v_reg = 3; cols_reg = 16; rows_reg = 16; thresh_reg = 1;
      send_idle_pct = 15;
      recv_idle_pct = 65;
      hold_off_cycles = 0;
      mismatches = 0;
      cycle_count = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: cubic four by four surface, ignored indices, parameter extremes.
      write_csr(CSR_COLS, GRID_SIDE);
      write_csr(CSR_ROWS, GRID_SIDE);
      load_surface(1'b0);
      pending_requests.push_back(make_req(REQ_LOAD_U, 31, 0, 32'h7FFFFFFF, 0, 0, 0, 0, 0));
      pending_requests.push_back(make_req(REQ_LOAD_P, 16, 15, 0, 32'h80000000,
                                          32'h7FFFFFFF, 32'hFFFFFFFF, 0, 0));
      pending_requests.push_back(make_req(REQ_EVAL, 0, 0, 0, 0, 0, 0,
                                          32'h80000000, 32'h80000000));
      pending_requests.push_back(make_req(REQ_EVAL, 0, 0, 0, 0, 0, 0,
                                          32'h7FFFFFFF, 32'h7FFFFFFF));
      pending_requests.push_back(make_req(REQ_EVAL, 0, 0, 0, 0, 0, 0, 0, 32'h7FFFFFFF));
      pending_requests.push_back(make_req(REQ_EVAL, 0, 0, 0, 0, 0, 0, 32'h00050000, 0));
      add_evals(4);
      drain();

      // Small grids with degree at or above count, and threshold extremes.
      write_csr(CSR_DEG_U, 1);
      write_csr(CSR_DEG_V, 0);
      write_csr(CSR_COLS, 2);
      write_csr(CSR_ROWS, 0);
      write_csr(CSR_THRESH, 16'hFFFF);
      load_surface(1'b1);
      add_evals(8);
      drain();

      write_csr(CSR_DEG_U, 3);
      write_csr(CSR_DEG_V, 2);
      write_csr(CSR_COLS, 3);
      write_csr(CSR_ROWS, 1);
      write_csr(CSR_THRESH, 0);
      // Long hold-off: results back up while evaluations keep arriving.
      hold_off_cycles = 20000;
      add_evals(10);
      drain();

      // Random phases with the sender idling more than the receiver, then with no idling.
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = ph == 0 ? 65 : 0;
         recv_idle_pct = ph == 0 ? 15 : 0;
         write_csr(CSR_DEG_U, $urandom_range(3));
         write_csr(CSR_DEG_V, $urandom_range(3));
         write_csr(CSR_COLS, $urandom_range(2, GRID_SIDE));
         write_csr(CSR_ROWS, $urandom_range(2, GRID_SIDE));
         write_csr(CSR_THRESH, $urandom_range(3) == 0 ? $urandom_range(16'hFFFF)
                                                      : $urandom_range(4));
         if (ph == 1) load_surface($urandom_range(1));
         add_evals(10);
         drain();
      end

      if (mismatches == 0 && expected_points.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/bsse_pkg.sv
rtl/bsse_div.sv
rtl/bsse_interp.sv
rtl/bspline_surface_evaluator.sv
rtl/bsse_checker.sv
tb/sv/tb_bspline_surface_evaluator.sv
